>>> design/indexed_insert_delete_list_macros.svh
// Assertion shorthands used by the checker file.
`ifndef INDEXED_INSERT_DELETE_LIST_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_MACROS_SVH

// Hold cons in the same cycle as ante.
`define INDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Hold cons in the cycle after ante.
`define INDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/indl_pkg.sv
`default_nettype none

package indl_pkg;

    // Fixed widths of the word ports
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int IDX_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    // Default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_DEL_LAST = 3'd2,
        CMD_DEL_AT   = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_GRAB,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> design/indexed_insert_delete_list.sv
`default_nettype none
// Packed list of up to CAPACITY signed words held in a single-port-write,
// single-port-read memory, with a fill count. Issue a command by raising
// start while busy is low; the word is taken on that edge and busy stays high
// until the result has been shown. The result appears on o_value_out,
// o_status and o_count_out for exactly one cycle with o_done high, and there
// is no way to hold it off, so capture it in that cycle. Rejected commands
// (full, empty, bad index) and unknown codes go straight to the done state;
// an append writes the word; a read fetches the entry; an insert at position
// p first moves each entry from p up one slot, then writes the word; a delete
// at p fetches the entry, then moves each entry above p down one slot. Each
// move reads an entry from the memory, then writes it back one slot along.
// Busy drops the cycle after o_done.

module indexed_insert_delete_list #(
    parameter int CAPACITY   = indl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = indl_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [indl_pkg::CMD_W-1:0]        i_command,
    input  logic signed [indl_pkg::VAL_W-1:0] i_value,
    input  logic [indl_pkg::IDX_W-1:0]        i_index,
    output logic                              o_done,
    output logic signed [indl_pkg::VAL_W-1:0] o_value_out,
    output logic [indl_pkg::ST_W-1:0]         o_status,
    output logic [indl_pkg::CNT_W-1:0]        o_count_out
);
    import indl_pkg::*;

    // Memory address, count, and common compare widths
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int WW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    // Entry store: undefined until written, only slots below the count feed results
    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic                  mem_we;
    logic [AW-1:0]         mem_wr_addr;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;

    // Control state
    t_state  r_state,  n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr,   n_ptr;     // slot about to be written during a shift
    logic [CW-1:0] r_pos,   n_pos;     // slot the command works on
    logic          r_up,    n_up;      // shift towards higher slots (insert)
    logic          r_rd_only, n_rd_only;

    // Payload
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [VAL_W-1:0]      r_value_out, n_value_out;
    t_status               r_status, n_status;

    // Shared pointer unit: one step and one loop test
    logic [CW-1:0] ptr_step;
    logic          more_moves;

    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic          is_full;
    logic          is_empty;
    logic [WW-1:0] in_wide;
    logic signed [WW-1:0] rd_wide;
    logic [XW-1:0] cnt_out_x;

    assign ptr_step   = r_up ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
    assign more_moves = r_up ? (r_ptr > r_pos) : (ptr_step < r_count);

    assign idx_x    = XW'(i_index);
    assign cnt_x    = XW'(r_count);
    assign is_full  = (r_count >= CW'(CAPACITY));
    assign is_empty = (r_count == '0);

    // Keep the low DATA_WIDTH bits on the way in, sign-extend on the way out
    assign in_wide = WW'($unsigned(i_value));
    assign rd_wide = WW'($signed(r_rdata));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_up        = r_up;
        n_rd_only   = r_rd_only;
        n_word      = r_word;
        n_value_out = r_value_out;
        n_status    = r_status;

        mem_we      = 1'b0;
        mem_wr_addr = r_ptr[AW-1:0];
        mem_rd_addr = r_pos[AW-1:0];
        mem_wr_data = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value_out = '0;
                    n_status    = ST_OK;
                    n_word      = in_wide[DATA_WIDTH-1:0];
                    n_state     = S_DONE;
                    case (i_command)
                        CMD_APPEND: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = r_count;
                                n_state = S_PUT;
                            end
                        end
                        CMD_INSERT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (idx_x > cnt_x) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                // open a gap from the top down to the index
                                n_pos   = idx_x[CW-1:0];
                                n_ptr   = r_count;
                                n_up    = 1'b1;
                                n_state = S_SHIFT_RD;
                            end
                        end
                        CMD_DEL_LAST: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_pos     = r_count - CW'(1);
                                n_up      = 1'b0;
                                n_rd_only = 1'b0;
                                n_state   = S_FETCH;
                            end
                        end
                        CMD_DEL_AT, CMD_READ: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (idx_x >= cnt_x) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_pos     = idx_x[CW-1:0];
                                n_up      = 1'b0;
                                n_rd_only = (i_command == CMD_READ);
                                n_state   = S_FETCH;
                            end
                        end
                        default: begin
                            // unknown code: no operation, report ok
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // read the addressed entry; data lands next cycle
                mem_rd_addr = r_pos[AW-1:0];
                n_state     = S_GRAB;
            end
            S_GRAB: begin
                n_value_out = rd_wide[VAL_W-1:0];
                if (r_rd_only) begin
                    n_state = S_DONE;
                end else begin
                    // close the gap: pull entries down from above
                    n_ptr   = r_pos;
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                mem_rd_addr = ptr_step[AW-1:0];
                if (more_moves) begin
                    n_state = S_SHIFT_WR;
                end else if (r_up) begin
                    n_state = S_PUT;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_ptr[AW-1:0];
                mem_wr_data = r_rdata;
                n_ptr       = ptr_step;
                n_state     = S_SHIFT_RD;
            end
            S_PUT: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_pos[AW-1:0];
                mem_wr_data = r_word;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_pos     <= '0;
            r_up      <= 1'b0;
            r_rd_only <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_pos     <= n_pos;
            r_up      <= n_up;
            r_rd_only <= n_rd_only;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_value_out <= n_value_out;
        r_status    <= n_status;
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rdata <= r_mem[mem_rd_addr];
    end

    // Count port carries the low bits of the fill count
    assign cnt_out_x = XW'(r_count);

    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_count_out = cnt_out_x[CNT_W-1:0];

endmodule

`default_nettype wire

>>> design/indl_checker.sv
`default_nettype none
`include "indexed_insert_delete_list_macros.svh"

module indl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic signed [indl_pkg::VAL_W-1:0] o_value_out,
    input logic [indl_pkg::ST_W-1:0]         o_status,
    input logic [indl_pkg::CNT_W-1:0]        o_count_out
);
    import indl_pkg::*;

    `INDL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word did not raise busy")
    `INDL_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy, "done shown while idle")
    `INDL_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "done held beyond one cycle")
    `INDL_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_value_out == '0, "failed command returned a value")
    `INDL_ASSERT_NOW(a_empty_cnt, i_clk, i_rst_n, o_done && (o_status == ST_EMPTY), o_count_out == '0, "empty status with nonzero count")

endmodule

bind indexed_insert_delete_list indl_checker u_indl_checker (.*);

`default_nettype wire

>>> verif/indexed_insert_delete_list_test.sv
module indexed_insert_delete_list_test;

    import indl_pkg::*;

    localparam int CAPACITY  = CAPACITY_DEF;
    localparam int HALF_CLK  = 4;
    localparam int RESET_CYC = 6;
    // Slowest command: delete at the head of a full list, plus margin for done/busy.
    localparam int SETTLE_CYC = 2 * CAPACITY + 8;
    localparam int RANDOM_WORDS = 1100;
    // The closing stretch runs back to back, with no idle cycles on the command side.
    localparam int TAIL_WORDS = 150;

    // The block treats these codes as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [VAL_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] WORD_ONES = 32'hffff_ffff;

    // Mix of operations in the random part.
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} t_mix;

    typedef struct {
        logic [VAL_W-1:0] value;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_list_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_command;
    logic signed [VAL_W-1:0] i_value;
    logic [IDX_W-1:0]     i_index;
    logic                 o_done;
    logic signed [VAL_W-1:0] o_value_out;
    logic [ST_W-1:0]      o_status;
    logic [CNT_W-1:0]     o_count_out;

    // Our own picture of the list contents, front at index 0.
    logic [VAL_W-1:0] list_mirror[$];
    // Results owed by the block, oldest first.
    t_list_result     owed_results[$];
    int unsigned      mismatches = 0;

    indexed_insert_delete_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_done      (o_done),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    initial i_clk = 1'b0;
    always #HALF_CLK i_clk = ~i_clk;

    // Apply one command to the mirror and return the result the block must give.
    // A full list is tested before the index, so a full list with a wild insert
    // index still reports full.
    function automatic t_list_result apply_list_command(logic [CMD_W-1:0] cmd,
                                                        logic [VAL_W-1:0] val,
                                                        logic [IDX_W-1:0] idx);
        t_list_result res;
        int unsigned  fill;
        res.value  = '0;
        res.status = ST_OK;
        fill = list_mirror.size();
        case (cmd)
            CMD_APPEND: begin
                if (fill >= CAPACITY) res.status = ST_FULL;
                else list_mirror.push_back(val);
            end
            CMD_INSERT: begin
                if (fill >= CAPACITY) res.status = ST_FULL;
                else if (idx > fill) res.status = ST_BAD_INDEX;
                else list_mirror.insert(idx, val);
            end
            CMD_DEL_LAST: begin
                if (fill == 0) res.status = ST_EMPTY;
                else res.value = list_mirror.pop_back();
            end
            CMD_DEL_AT: begin
                if (fill == 0) res.status = ST_EMPTY;
                else if (idx >= fill) res.status = ST_BAD_INDEX;
                else begin
                    res.value = list_mirror[idx];
                    list_mirror.delete(idx);
                end
            end
            CMD_READ: begin
                if (fill == 0) res.status = ST_EMPTY;
                else if (idx >= fill) res.status = ST_BAD_INDEX;
                else res.value = list_mirror[idx];
            end
            default: ;  // spare codes: nothing moves, status ok
        endcase
        res.count = CNT_W'(list_mirror.size());
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one command word at the falling edge and hold it until it is taken.
    // Start stays high on return, so a word sent straight after follows with no gap.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                             logic [IDX_W-1:0] idx);
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        i_index   <= idx;
        do @(posedge i_clk); while (busy);
        // Taken on this edge: book the result before the block can produce it.
        owed_results.push_back(apply_list_command(cmd, val, idx));
        @(negedge i_clk);
    endtask

    task automatic idle_for(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Compare each strobed result, field by field, with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result with none owed", o_value_out, '0);
            end else begin
                want = owed_results.pop_front();
                if (o_value_out !== want.value)
                    report_mismatch("value_out", o_value_out, want.value);
                if (o_status !== want.status)
                    report_mismatch("status", VAL_W'(o_status), VAL_W'(want.status));
                if (o_count_out !== want.count)
                    report_mismatch("count_out", VAL_W'(o_count_out), VAL_W'(want.count));
            end
        end
    end

    // Mostly random words, with the most negative and most positive words, zero and all-ones mixed in.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position for the current fill, sometimes any position up to CAPACITY,
    // and now and then anywhere in the five-bit field.
    function automatic logic [IDX_W-1:0] pick_index(logic [CMD_W-1:0] cmd);
        int unsigned fill;
        int unsigned r;
        fill = list_mirror.size();
        r = $urandom_range(0, 99);
        if (r < 80) begin
            if (cmd == CMD_INSERT) return IDX_W'($urandom_range(0, fill));
            if (fill == 0) return '0;
            return IDX_W'($urandom_range(0, fill - 1));
        end
        if (r < 95) return IDX_W'($urandom_range(0, CAPACITY));
        return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(t_mix mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 45) return CMD_APPEND;
                if (r < 70) return CMD_INSERT;
                if (r < 80) return CMD_DEL_LAST;
                if (r < 90) return CMD_DEL_AT;
                return CMD_READ;
            end
            MIX_SHRINK: begin
                if (r < 10) return CMD_APPEND;
                if (r < 20) return CMD_INSERT;
                if (r < 50) return CMD_DEL_LAST;
                if (r < 80) return CMD_DEL_AT;
                return CMD_READ;
            end
            default: begin
                if (r < 20) return CMD_APPEND;
                if (r < 40) return CMD_INSERT;
                if (r < 55) return CMD_DEL_LAST;
                if (r < 70) return CMD_DEL_AT;
                return CMD_READ;
            end
        endcase
    endfunction

    // Everything that needs entries must refuse on an empty list; spare codes
    // do nothing, and an insert past the end of an empty list is a bad index.
    task automatic test_empty_list();
        send_word(CMD_DEL_LAST, pick_value(), '0);
        send_word(CMD_DEL_AT, pick_value(), '0);
        send_word(CMD_READ, pick_value(), '0);
        send_word(CMD_SPARE_LO, WORD_ONES, '1);
        send_word(CMD_SPARE_HI, WORD_MAX, '0);
        send_word(CMD_INSERT, WORD_MIN, 5'd1);
    endtask

    // Fill to capacity through the head, the tail and the middle, with the
    // extreme words first, then push against the full list.
    task automatic test_fill_to_capacity();
        int unsigned k;
        for (k = 0; k < CAPACITY; k++) begin
            case (k % 3)
                0: send_word(CMD_APPEND, k == 0 ? WORD_MIN : pick_value(), '0);
                1: send_word(CMD_INSERT, k == 1 ? WORD_MAX : pick_value(), '0);
                default: send_word(CMD_INSERT, k == 2 ? WORD_ONES : pick_value(),
                                   IDX_W'(list_mirror.size() / 2));
            endcase
            // An insert one past the end on a partly filled list must be refused.
            if (k == 5) send_word(CMD_INSERT, pick_value(), IDX_W'(list_mirror.size() + 1));
        end
        send_word(CMD_APPEND, pick_value(), '0);
        // Full takes precedence over a wild index.
        send_word(CMD_INSERT, pick_value(), '1);
    endtask

    // Reads at and just beyond the end of a full list, a delete beyond it, then deletes at the head and the tail.
    task automatic test_full_list_edges();
        send_word(CMD_READ, '0, 5'(CAPACITY - 1));
        send_word(CMD_READ, '0, 5'(CAPACITY));
        send_word(CMD_DEL_AT, '0, 5'(CAPACITY));
        send_word(CMD_DEL_AT, '0, '0);
        send_word(CMD_DEL_LAST, '0, '0);
    endtask

    // Random words in spells that push the fill up, pull it down or churn it,
    // so the list keeps passing through empty, full and everything between.
    task automatic test_random_commands(int unsigned n_words);
        int unsigned      k;
        t_mix             mix;
        logic [CMD_W-1:0] cmd;
        mix = MIX_CHURN;
        for (k = 0; k < n_words; k++) begin
            if (k % 48 == 0) mix = t_mix'($urandom_range(0, 2));
            if ($urandom_range(0, 99) < 4)
                cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            else
                cmd = pick_command(mix);
            send_word(cmd, pick_value(), pick_index(cmd));
            // Idle now and then, outside the closing stretch, so start also drops while a command is under way.
            if (k + TAIL_WORDS < n_words && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 13));
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_command = CMD_APPEND;
        i_value   = '0;
        i_index   = '0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_fill_to_capacity();
        test_full_list_edges();
        test_random_commands(RANDOM_WORDS);

        // Drop start, drain what is owed, then watch a while for strays.
        start <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run of this stimulus.
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
